// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent check helpers; clk and arst_n must be in scope at the use site.
`ifndef SYNTHESIS
`define SLD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define SLD_ASSERT_DELAY(label, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("delayed check failed");
`else
`define SLD_ASSERT_IMPL(label, ante, cons)
`define SLD_ASSERT_DELAY(label, ante, dly, cons)
`endif
`endif

// File: src/sld_pkg.sv
package sld_pkg;

	// field widths
	localparam int CW = 24;
	localparam int DW = 16;

	// derived arithmetic widths
	localparam int PW   = 2 * DW;          // direction product
	localparam int NW   = PW + 1;          // normal component
	localparam int CDW  = CW + 1;          // point difference
	localparam int SPW  = CDW + NW;        // c*n product
	localparam int SW   = SPW + 2;         // s = c.n
	localparam int AW   = SW;              // |s|
	localparam int HW   = AW / 2;          // low half of |s|
	localparam int HIW  = AW - HW;         // high half of |s|
	localparam int NSQW = 2 * NW;          // n_i^2
	localparam int NNW  = NSQW + 2;        // N = n.n
	localparam int SSW  = 2 * AW + 2;      // 4 s^2
	localparam int RW   = CW + 1;          // root width
	localparam int QW   = 2 * RW;          // clamped quotient width
	localparam int RMW  = RW + 2;          // root remainder
	localparam int CMPW = (SSW > NNW + QW) ? SSW : NNW + QW;

	typedef struct packed {
		logic signed [DW-1:0] first_dir_x;
		logic signed [DW-1:0] first_dir_y;
		logic signed [DW-1:0] first_dir_z;
		logic signed [CW-1:0] first_point_x;
		logic signed [CW-1:0] first_point_y;
		logic signed [CW-1:0] first_point_z;
		logic signed [DW-1:0] second_dir_x;
		logic signed [DW-1:0] second_dir_y;
		logic signed [DW-1:0] second_dir_z;
		logic signed [CW-1:0] second_point_x;
		logic signed [CW-1:0] second_point_y;
		logic signed [CW-1:0] second_point_z;
	} in_t;

	typedef struct packed {
		logic [CW-1:0] distance;
		logic          valid_res;
	} out_t;

	// sideband that travels with each beat
	typedef struct packed {
		logic vld;
		logic par;
		logic sat;
	} sld_meta_t;

endpackage

// File: src/skew_line_distance.sv
// Distance of closest approach between two 3D lines.
// Input: one beat per pair of lines on item, taken at a clock edge with start
// high; busy is always low, so a new pair may be offered in every cycle.
// Output: done is high for one cycle with result; the receiver must take it,
// there is no back-pressure. Exactly one result per accepted pair, in order.
// Pipeline: 8 arithmetic stages, 50 divider stages, 25 root stages and the
// output register lie between accepting a pair and its result. Throughput: one
// pair per cycle, set by the fully pipelined divider and square-root chains.
// Method: Q = floor(4 s^2 / N) with s = (p1-p0).n and N = n.n; r = isqrt(Q);
// distance = (r+1)/2, saturated when Q or the rounded root is out of range.
// Parallel lines (zero normal) give valid_res = 0 and distance = 0.
// Reset: asynchronous, clears all valid bits; beats in flight are dropped.
`include "assert_macros.svh"

module skew_line_distance (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sld_pkg::in_t  item,
	output logic          done,
	output sld_pkg::out_t result
);

	localparam int CW  = sld_pkg::CW;
	localparam int SSW = sld_pkg::SSW;
	localparam int NNW = sld_pkg::NNW;
	localparam int QW  = sld_pkg::QW;
	localparam int RW  = sld_pkg::RW;
	localparam int LAT = QW + RW + 9;

	logic [SSW-1:0]     dividend;
	logic [NNW-1:0]     divisor;
	logic [QW-1:0]      quotient;
	logic [RW-1:0]      root;
	logic [RW:0]        root_inc;
	sld_pkg::sld_meta_t meta_front, meta_div, meta_sqrt;
	logic               done_q;
	sld_pkg::out_t      result_q;

	assign busy = 1'b0;

	sld_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start),
		.in_data  (item),
		.dividend (dividend),
		.divisor  (divisor),
		.meta     (meta_front)
	);

	sld_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.dividend (dividend),
		.divisor  (divisor),
		.meta_in  (meta_front),
		.quotient (quotient),
		.meta_out (meta_div)
	);

	sld_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.radicand (quotient),
		.meta_in  (meta_div),
		.root     (root),
		.meta_out (meta_sqrt)
	);

	// round: largest d with 2d-1 <= r
	assign root_inc = {1'b0, root} + (RW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= meta_sqrt.vld;
		end
	end

	// output register; top root gives one past the field, so it saturates too
	always_ff @(posedge clk) begin
		priority if (meta_sqrt.par) begin
			result_q <= '{distance: '0, valid_res: 1'b0};
		end else if (meta_sqrt.sat || root_inc[RW]) begin
			result_q <= '{distance: '1, valid_res: 1'b1};
		end else begin
			result_q <= '{distance: root_inc[CW:1], valid_res: 1'b1};
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`SLD_ASSERT_DELAY(a_latency, start && !busy, LAT, done)
	`SLD_ASSERT_IMPL(a_parallel_zero, done && !result.valid_res, result.distance == '0)
	`SLD_ASSERT_DELAY(a_sat_full, meta_sqrt.vld && meta_sqrt.sat && !meta_sqrt.par, 1, done && result.distance == '1)

endmodule

// File: src/sld_front.sv
module sld_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  sld_pkg::in_t                in_data,
	output logic [sld_pkg::SSW-1:0]     dividend,
	output logic [sld_pkg::NNW-1:0]     divisor,
	output sld_pkg::sld_meta_t          meta
);

	localparam int PW   = sld_pkg::PW;
	localparam int NW   = sld_pkg::NW;
	localparam int CDW  = sld_pkg::CDW;
	localparam int SPW  = sld_pkg::SPW;
	localparam int SW   = sld_pkg::SW;
	localparam int AW   = sld_pkg::AW;
	localparam int HW   = sld_pkg::HW;
	localparam int HIW  = sld_pkg::HIW;
	localparam int NSQW = sld_pkg::NSQW;
	localparam int NNW  = sld_pkg::NNW;
	localparam int SSW  = sld_pkg::SSW;
	localparam int QW   = sld_pkg::QW;
	localparam int CMPW = sld_pkg::CMPW;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic par_s3, par_s4, par_s5, par_s6, par_s7, par_s8, sat_s8;

	logic signed [PW-1:0]  pyz_s1, pzy_s1, pzx_s1, pxz_s1, pxy_s1, pyx_s1;
	logic signed [CDW-1:0] cx_s1, cy_s1, cz_s1, cx_s2, cy_s2, cz_s2;
	logic signed [NW-1:0]  nx_s2, ny_s2, nz_s2;
	logic signed [SPW-1:0] cnx_s3, cny_s3, cnz_s3;
	logic [NSQW-1:0]       nnx_s3, nny_s3, nnz_s3;
	logic signed [SW-1:0]  s_s4;
	logic [NNW-1:0]        nn_s4, nn_s5, nn_s6, nn_s7, nn_s8;
	logic [AW-1:0]         a_s5;
	logic [2*HW-1:0]       ll_s6;
	logic [HW+HIW-1:0]     lh_s6;
	logic [2*HIW-1:0]      hh_s6;
	logic [SSW-1:0]        sq4_s7, sq4_s8;

	logic signed [NSQW-1:0] nnx_w, nny_w, nnz_w;
	logic [AW-1:0]          lo_w, hi_w;

	assign nnx_w = nx_s2 * nx_s2;
	assign nny_w = ny_s2 * ny_s2;
	assign nnz_w = nz_s2 * nz_s2;
	assign lo_w  = AW'(a_s5[HW-1:0]);
	assign hi_w  = AW'(a_s5[AW-1:HW]);

	// valid and flag pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8} <= '0;
			{par_s3, par_s4, par_s5, par_s6, par_s7, par_s8, sat_s8} <= '0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			par_s3 <= (nx_s2 == '0) && (ny_s2 == '0) && (nz_s2 == '0);
			par_s4 <= par_s3;
			par_s5 <= par_s4;
			par_s6 <= par_s5;
			par_s7 <= par_s6;
			par_s8 <= par_s7;
			// quotient would not fit: distance saturates
			sat_s8 <= CMPW'(sq4_s7) >= (CMPW'(nn_s7) << QW);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		// s1: direction products, point differences
		pyz_s1 <= in_data.first_dir_y * in_data.second_dir_z;
		pzy_s1 <= in_data.first_dir_z * in_data.second_dir_y;
		pzx_s1 <= in_data.first_dir_z * in_data.second_dir_x;
		pxz_s1 <= in_data.first_dir_x * in_data.second_dir_z;
		pxy_s1 <= in_data.first_dir_x * in_data.second_dir_y;
		pyx_s1 <= in_data.first_dir_y * in_data.second_dir_x;
		cx_s1  <= CDW'(in_data.second_point_x) - CDW'(in_data.first_point_x);
		cy_s1  <= CDW'(in_data.second_point_y) - CDW'(in_data.first_point_y);
		cz_s1  <= CDW'(in_data.second_point_z) - CDW'(in_data.first_point_z);
		// s2: normal
		nx_s2 <= NW'(pyz_s1) - NW'(pzy_s1);
		ny_s2 <= NW'(pzx_s1) - NW'(pxz_s1);
		nz_s2 <= NW'(pxy_s1) - NW'(pyx_s1);
		cx_s2 <= cx_s1;
		cy_s2 <= cy_s1;
		cz_s2 <= cz_s1;
		// s3: component products
		cnx_s3 <= cx_s2 * nx_s2;
		cny_s3 <= cy_s2 * ny_s2;
		cnz_s3 <= cz_s2 * nz_s2;
		nnx_s3 <= nnx_w;
		nny_s3 <= nny_w;
		nnz_s3 <= nnz_w;
		// s4: dot products
		s_s4  <= SW'(cnx_s3) + SW'(cny_s3) + SW'(cnz_s3);
		nn_s4 <= NNW'(nnx_s3) + NNW'(nny_s3) + NNW'(nnz_s3);
		// s5: magnitude
		a_s5  <= s_s4[SW-1] ? AW'(-s_s4) : AW'(s_s4);
		nn_s5 <= nn_s4;
		// s6: partial squares
		ll_s6 <= (2*HW)'(lo_w * lo_w);
		lh_s6 <= (HW+HIW)'(lo_w * hi_w);
		hh_s6 <= (2*HIW)'(hi_w * hi_w);
		nn_s6 <= nn_s5;
		// s7: 4 s^2
		sq4_s7 <= ((SSW'(hh_s6) << (2*HW)) + (SSW'(lh_s6) << (HW+1)) + SSW'(ll_s6)) << 2;
		nn_s7  <= nn_s6;
		// s8
		sq4_s8 <= sq4_s7;
		nn_s8  <= nn_s7;
	end

	assign dividend = sq4_s8;
	assign divisor  = nn_s8;
	assign meta     = '{vld: vld_s8, par: par_s8, sat: sat_s8};

endmodule

// File: src/sld_div.sv
module sld_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [sld_pkg::SSW-1:0]    dividend,
	input  logic [sld_pkg::NNW-1:0]    divisor,
	input  sld_pkg::sld_meta_t         meta_in,
	output logic [sld_pkg::QW-1:0]     quotient,
	output sld_pkg::sld_meta_t         meta_out
);

	localparam int NNW = sld_pkg::NNW;
	localparam int QW  = sld_pkg::QW;

	logic [NNW-1:0]     rem_s [QW];
	logic [NNW-1:0]     dvs_s [QW];
	logic [QW-1:0]      lo_s  [QW];
	logic [QW-1:0]      quo_s [QW];
	sld_pkg::sld_meta_t meta_s[QW];

	// one quotient bit per stage, restoring
	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [NNW-1:0]     rem_i, dvs_i;
		logic [QW-1:0]      lo_i, quo_i;
		sld_pkg::sld_meta_t meta_i;
		logic [NNW:0]       trial;
		logic               ge;

		if (i == 0) begin : g_first
			assign rem_i  = dividend[QW+NNW-1:QW];
			assign lo_i   = dividend[QW-1:0];
			assign quo_i  = '0;
			assign dvs_i  = divisor;
			assign meta_i = meta_in;
		end else begin : g_next
			assign rem_i  = rem_s[i-1];
			assign lo_i   = lo_s[i-1];
			assign quo_i  = quo_s[i-1];
			assign dvs_i  = dvs_s[i-1];
			assign meta_i = meta_s[i-1];
		end

		assign trial = {rem_i, lo_i[QW-1]};
		assign ge    = trial >= {1'b0, dvs_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				meta_s[i] <= '0;
			end else begin
				meta_s[i] <= meta_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? NNW'(trial - {1'b0, dvs_i}) : trial[NNW-1:0];
			lo_s[i]  <= {lo_i[QW-2:0], 1'b0};
			quo_s[i] <= {quo_i[QW-2:0], ge};
			dvs_s[i] <= dvs_i;
		end
	end

	assign quotient = quo_s[QW-1];
	assign meta_out = meta_s[QW-1];

endmodule

// File: src/sld_sqrt.sv
module sld_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [sld_pkg::QW-1:0]     radicand,
	input  sld_pkg::sld_meta_t         meta_in,
	output logic [sld_pkg::RW-1:0]     root,
	output sld_pkg::sld_meta_t         meta_out
);

	localparam int QW  = sld_pkg::QW;
	localparam int RW  = sld_pkg::RW;
	localparam int RMW = sld_pkg::RMW;

	logic [QW-1:0]      rad_s [RW];
	logic [RMW-1:0]     rem_s [RW];
	logic [RW-1:0]      root_s[RW];
	sld_pkg::sld_meta_t meta_s[RW];

	// one root bit per stage
	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [QW-1:0]      rad_i;
		logic [RMW-1:0]     rem_i, t, trial;
		logic [RW-1:0]      root_i;
		sld_pkg::sld_meta_t meta_i;
		logic               ge;

		if (i == 0) begin : g_first
			assign rad_i  = radicand;
			assign rem_i  = '0;
			assign root_i = '0;
			assign meta_i = meta_in;
		end else begin : g_next
			assign rad_i  = rad_s[i-1];
			assign rem_i  = rem_s[i-1];
			assign root_i = root_s[i-1];
			assign meta_i = meta_s[i-1];
		end

		assign t     = {rem_i[RMW-3:0], rad_i[QW-1:QW-2]};
		assign trial = {root_i, 2'b01};
		assign ge    = t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				meta_s[i] <= '0;
			end else begin
				meta_s[i] <= meta_i;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[i]  <= {rad_i[QW-3:0], 2'b00};
			rem_s[i]  <= ge ? (t - trial) : t;
			root_s[i] <= {root_i[RW-2:0], ge};
		end
	end

	assign root     = root_s[RW-1];
	assign meta_out = meta_s[RW-1];

endmodule
